[design/fpa_pkg.sv]
// fpa_pkg: constants, codes, command/status structs and width helpers
// shared by the fit partition allocator controller, datapath and top level
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int BLOCKS     = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_BITS   = $clog2(BLOCKS + 1);

  localparam int AMOUNT_W   = 16;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int BLK_W      = 4;
  localparam int LEFT_W     = 16;
  localparam int MODE_W     = 2;
  localparam int ACTIVE_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 1'd1;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_LOAD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic write;
    logic out_load;
  } fpa_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } fpa_stat_t;

  function automatic logic [SIZE_BITS-1:0] to_size(input logic [AMOUNT_W-1:0] a);
    logic [SIZE_BITS+AMOUNT_W-1:0] t;
    t = {{SIZE_BITS{1'b0}}, a};
    return t[SIZE_BITS-1:0];
  endfunction

  function automatic logic [LEFT_W-1:0] to_left(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS+LEFT_W-1:0] t;
    t = {{LEFT_W{1'b0}}, s};
    return t[LEFT_W-1:0];
  endfunction

  function automatic logic [IDX_BITS-1:0] to_idx(input logic [SLOT_W-1:0] s);
    logic [IDX_BITS+SLOT_W-1:0] t;
    t = {{IDX_BITS{1'b0}}, s};
    return t[IDX_BITS-1:0];
  endfunction

  function automatic logic [BLK_W-1:0] to_blk(input logic [IDX_BITS-1:0] i);
    logic [IDX_BITS+BLK_W-1:0] t;
    t = {{BLK_W{1'b0}}, i};
    return t[BLK_W-1:0];
  endfunction

  // free size at least the request, compared at full width of both
  function automatic logic fits(input logic [SIZE_BITS-1:0] s,
                                input logic [AMOUNT_W-1:0] a);
    logic [SIZE_BITS+AMOUNT_W-1:0] ws;
    logic [SIZE_BITS+AMOUNT_W-1:0] wa;
    ws = {{AMOUNT_W{1'b0}}, s};
    wa = {{SIZE_BITS{1'b0}}, a};
    return ws >= wa;
  endfunction

endpackage

[design/fpa_ctrl.sv]
// fpa_ctrl: sequencing state machine of the allocator
// depends on fpa_pkg for the command and status structs
`timescale 1ns / 1ps

module fpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  fpa_pkg::fpa_stat_t stat,
  output fpa_pkg::fpa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == fpa_pkg::OP_LOAD) begin
            cmd.load   = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.start  = 1'b1;
            state_next = stat.count_zero ? S_WRITE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/fpa_datapath.sv]
// fpa_datapath: config registers, free size memory, scan compare,
// result and output registers; depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [fpa_pkg::SLOT_W-1:0]          block_slot,
  input  logic [fpa_pkg::AMOUNT_W-1:0]        amount,
  input  fpa_pkg::fpa_cmd_t                   cmd,
  output fpa_pkg::fpa_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [fpa_pkg::STATUS_W-1:0]        status,
  output logic [fpa_pkg::BLK_W-1:0]           chosen_block,
  output logic [fpa_pkg::LEFT_W-1:0]          left_over
);

  logic [fpa_pkg::MODE_W-1:0]    fit_mode;
  logic [fpa_pkg::ACTIVE_W-1:0]  active_blocks;

  logic [fpa_pkg::SIZE_BITS-1:0] mem [fpa_pkg::BLOCKS];
  logic [fpa_pkg::SIZE_BITS-1:0] rd_data;
  logic                          rd_vld;
  logic [fpa_pkg::IDX_BITS-1:0]  rd_idx;

  logic [fpa_pkg::CNT_BITS-1:0]  scan_cnt;
  logic [fpa_pkg::CNT_BITS-1:0]  scan_cnt_inc;
  logic [fpa_pkg::CNT_BITS-1:0]  cnt_lim;
  logic [fpa_pkg::CNT_BITS-1:0]  cnt_lim_next;
  logic [fpa_pkg::IDX_BITS-1:0]  scan_idx;

  logic [fpa_pkg::AMOUNT_W-1:0]  req;
  logic                          found;
  logic [fpa_pkg::IDX_BITS-1:0]  pick;
  logic [fpa_pkg::SIZE_BITS-1:0] best;
  logic                          take;
  logic [fpa_pkg::SIZE_BITS-1:0] left_new;
  logic                          slot_ok;

  logic [fpa_pkg::STATUS_W-1:0]  res_status;
  logic [fpa_pkg::BLK_W-1:0]     res_blk;
  logic [fpa_pkg::LEFT_W-1:0]    res_left;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= fpa_pkg::MODE_FIRST;
      active_blocks <= fpa_pkg::ACTIVE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fpa_pkg::REG_FIT_MODE: fit_mode      <= cfg_data[fpa_pkg::MODE_W-1:0];
        fpa_pkg::REG_ACTIVE:   active_blocks <= cfg_data[fpa_pkg::ACTIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // active count saturated to the table depth
  always_comb begin
    if (32'(active_blocks) > 32'(fpa_pkg::BLOCKS)) begin
      cnt_lim_next = fpa_pkg::CNT_BITS'(fpa_pkg::BLOCKS);
    end else begin
      cnt_lim_next = fpa_pkg::CNT_BITS'(active_blocks);
    end
  end

  assign scan_cnt_inc = scan_cnt + fpa_pkg::CNT_BITS'(1);
  assign scan_idx     = scan_cnt[fpa_pkg::IDX_BITS-1:0];
  assign slot_ok      = 32'(block_slot) < 32'(fpa_pkg::BLOCKS);
  assign left_new     = best - fpa_pkg::to_size(req);

  assign stat.count_zero = (active_blocks == '0);
  assign stat.scan_last  = (scan_cnt_inc == cnt_lim);
  assign stat.out_free   = !out_valid || out_ready;

  // strict compares keep the lowest index on ties
  always_comb begin
    take = 1'b0;
    if (rd_vld && fpa_pkg::fits(rd_data, req)) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_mode == fpa_pkg::MODE_BEST) begin
        take = (rd_data < best);
      end else if (fit_mode == fpa_pkg::MODE_WORST) begin
        take = (rd_data > best);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      mem[fpa_pkg::to_idx(block_slot)] <= fpa_pkg::to_size(amount);
    end else if (cmd.write && found) begin
      mem[pick] <= left_new;
    end
    if (cmd.issue) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx   <= scan_idx;
      scan_cnt <= scan_cnt_inc;
    end
    if (cmd.start) begin
      req      <= amount;
      cnt_lim  <= cnt_lim_next;
      scan_cnt <= '0;
    end
    if (take) begin
      pick <= rd_idx;
      best <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= fpa_pkg::ST_LOAD;
      res_blk    <= block_slot;
      res_left   <= slot_ok ? fpa_pkg::to_left(fpa_pkg::to_size(amount)) : '0;
    end else if (cmd.write) begin
      if (found) begin
        res_status <= fpa_pkg::ST_ALLOC;
        res_blk    <= fpa_pkg::to_blk(pick);
        res_left   <= fpa_pkg::to_left(left_new);
      end else begin
        res_status <= fpa_pkg::ST_NONE;
        res_blk    <= '0;
        res_left   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status;
      chosen_block <= res_blk;
      left_over    <= res_left;
    end
  end

`ifndef SYNTH
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while still pending");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    found |-> (32'(pick) < 32'(cnt_lim)))
    else $error("picked block outside the active range");

  a_writeback_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && found) |-> fpa_pkg::fits(best, req))
    else $error("chosen block smaller than request");

  a_take_updates: assert property (@(posedge clk) disable iff (rst)
    (take && !cmd.start) |=> (found && pick == $past(rd_idx)))
    else $error("candidate not captured");
`endif

endmodule

[design/fit_partition_allocator.sv]
// fit_partition_allocator: top level joining controller and datapath
// depends on fpa_pkg, fpa_ctrl and fpa_datapath
// load: result register on acceptance, then output register once it is free;
// allocate: scans n active blocks (saturated to the table depth) one entry per cycle
// via the single read port of the free table, then drain, write-back, output;
// no scan if none are active; a new request is taken only once the result is output
// reset: fit mode first fit, 16 active blocks, no result pending; free
// sizes are unknown until loaded
`timescale 1ns / 1ps

module fit_partition_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [fpa_pkg::SLOT_W-1:0]     block_slot,
  input  logic [fpa_pkg::AMOUNT_W-1:0]   amount,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fpa_pkg::STATUS_W-1:0]   status,
  output logic [fpa_pkg::BLK_W-1:0]      chosen_block,
  output logic [fpa_pkg::LEFT_W-1:0]     left_over
);

  fpa_pkg::fpa_cmd_t  cmd;
  fpa_pkg::fpa_stat_t stat;

  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .block_slot   (block_slot),
    .amount       (amount),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .chosen_block (chosen_block),
    .left_over    (left_over)
  );

endmodule

[bench/tb_fit_partition_allocator.sv]
// tb_fit_partition_allocator: self-checking bench for the fit partition allocator
// drives loads, allocates and register writes, predicts each result, checks in order
// depends on fpa_pkg and fit_partition_allocator
`timescale 1ns / 1ps

module tb_fit_partition_allocator;
  import fpa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    blk;
    logic [LEFT_W-1:0]   left;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_LOAD;
  logic [SLOT_W-1:0]     block_slot = '0;
  logic [AMOUNT_W-1:0]   amount = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [BLK_W-1:0]      chosen_block;
  logic [LEFT_W-1:0]     left_over;

  logic [SIZE_BITS-1:0] free_table [BLOCKS];
  logic [MODE_W-1:0]    fit_mode_q = MODE_FIRST;
  logic [ACTIVE_W-1:0]  active_q = ACTIVE_RESET;
  alloc_result_t        pending_results [$];
  int                   error_count = 0;
  int                   idle_cycles = 0;
  int                   out_stall_left = 0;
  bit                   calm = 1'b0;
  int                   seed_sizes [BLOCKS] = '{100, 0, 300, 65535, 200, 5000, 300, 1,
                                                400, 249, 1000, 65535, 7, 320, 2, 30000};

  fit_partition_allocator i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .block_slot(block_slot), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .chosen_block(chosen_block), .left_over(left_over)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void predict_allocation(input logic op_i,
                                             input logic [SLOT_W-1:0] slot_i,
                                             input logic [AMOUNT_W-1:0] amt_i);
    alloc_result_t res;
    int span;
    int j;
    int pick;
    bit found;
    found = 1'b0;
    pick = 0;
    if (op_i == OP_LOAD) begin
      free_table[slot_i] = amt_i;
      res = '{ST_LOAD, slot_i, amt_i};
    end else begin
      span = (int'(active_q) > BLOCKS) ? BLOCKS : int'(active_q);
      for (j = 0; j < span; j++) begin
        if (free_table[j] >= amt_i) begin
          if (!found) begin
            found = 1'b1;
            pick = j;
          end else if (fit_mode_q == MODE_BEST && free_table[j] < free_table[pick]) begin
            pick = j;
          end else if (fit_mode_q == MODE_WORST && free_table[j] > free_table[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        free_table[pick] = free_table[pick] - amt_i;
        res = '{ST_ALLOC, pick[BLK_W-1:0], free_table[pick]};
      end else begin
        res = '{ST_NONE, '0, '0};
      end
    end
    pending_results.push_back(res);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_item(input logic op_i, input logic [SLOT_W-1:0] slot_i,
                           input logic [AMOUNT_W-1:0] amt_i);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= op_i;
    block_slot <= slot_i;
    amount     <= amt_i;
    do @(posedge clk); while (!in_ready);
    predict_allocation(op_i, slot_i, amt_i);
  endtask

  // hold the input side until every expected result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FIT_MODE) fit_mode_q = data[MODE_W-1:0];
    else active_q = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_load_table();
    int i;
    for (i = 0; i < BLOCKS; i++) begin
      send_item(OP_LOAD, i[SLOT_W-1:0], seed_sizes[i][AMOUNT_W-1:0]);
    end
  endtask

  // ties, zero request and the spare mode code
  task automatic test_fit_modes();
    write_reg(REG_FIT_MODE, CFG_DATA_W'(MODE_FIRST));
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd250);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd0);
    write_reg(REG_FIT_MODE, CFG_DATA_W'(MODE_BEST));
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd250);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd0);
    write_reg(REG_FIT_MODE, CFG_DATA_W'(MODE_WORST));
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd60000);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd0);
    write_reg(REG_FIT_MODE, CFG_DATA_W'(MODE_SPARE));
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd250);
  endtask

  // no blocks, saturated count, no fit, single block
  task automatic test_search_limits();
    write_reg(REG_ACTIVE, 5'd0);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd0);
    write_reg(REG_ACTIVE, 5'd31);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'hFFFF);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'hFFFF);
    write_reg(REG_ACTIVE, 5'd1);
    send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd101);
    write_reg(REG_ACTIVE, ACTIVE_RESET);
    write_reg(REG_FIT_MODE, CFG_DATA_W'(MODE_FIRST));
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int k;
    int roll;
    logic [AMOUNT_W-1:0] amt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) != 0) begin
        roll = $urandom_range(0, 9);
        write_reg(REG_FIT_MODE,
                  CFG_DATA_W'((roll == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3)));
      end
      if ($urandom_range(0, 2) != 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) write_reg(REG_ACTIVE, CFG_DATA_W'($urandom_range(1, 16)));
        else if (roll < 80) write_reg(REG_ACTIVE, ACTIVE_RESET);
        else if (roll < 88) write_reg(REG_ACTIVE, 5'd0);
        else write_reg(REG_ACTIVE, CFG_DATA_W'($urandom_range(17, 31)));
      end
      burst = $urandom_range(30, 120);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      for (k = 0; k < burst; k++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 35) begin
          if (roll < 10) amt = '0;
          else if (roll < 20) amt = '1;
          else if (roll < 60) amt = AMOUNT_W'($urandom_range(0, 2000));
          else amt = AMOUNT_W'($urandom_range(0, 65535));
          send_item(OP_LOAD, SLOT_W'($urandom_range(0, 15)), amt);
        end else begin
          if (roll < 10) amt = '0;
          else if (roll < 15) amt = '1;
          else if (roll < 75) amt = AMOUNT_W'($urandom_range(0, 1500));
          else amt = AMOUNT_W'($urandom_range(0, 65535));
          send_item(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), amt);
        end
      end
      sent += burst;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_ready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      out_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with none expected: status %0d block %0d left %0d",
                               status, chosen_block, left_over));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_error($sformatf("status %0d, expected %0d", status, want.status));
        if (chosen_block !== want.blk)
          report_error($sformatf("chosen_block %0d, expected %0d", chosen_block, want.blk));
        if (left_over !== want.left)
          report_error($sformatf("left_over %0d, expected %0d", left_over, want.left));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_table();
    test_fit_modes();
    test_search_limits();
    test_random_traffic();
    wait_idle();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
